FILE: rtl/core/ospq_pkg.sv
// ----------------------------------------------------------------------------
// ospq_pkg
// shared types, sizes and codes for the oldest-first priority swap queue
// ----------------------------------------------------------------------------
package ospq_pkg;

  // queue geometry
  localparam int DEPTH = 16;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // one stored entry
  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  pri;
    logic [31:0] stime;
  } entry_t;

  // compare unit result
  typedef struct packed {
    logic later;   // entry time greater than pick time
    logic higher;  // entry priority strictly above pick priority
  } cmp_res_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT
  } state_t;

endpackage

FILE: rtl/core/ospq_store.sv
// ----------------------------------------------------------------------------
// ospq_store
// entry memory: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module ospq_store
  import ospq_pkg::*;
(
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  entry_t          wr_data,
  input  logic [AW-1:0]   rd_addr,
  output entry_t          rd_data
);

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/core/ospq_cmp.sv
// ----------------------------------------------------------------------------
// ospq_cmp
// shared compare unit: one scanned entry against the current pick
// ----------------------------------------------------------------------------
module ospq_cmp
  import ospq_pkg::*;
(
  input  logic [31:0] pick_time,
  input  logic [7:0]  pick_pri,
  input  entry_t      entry,
  output cmp_res_t    res
);

  // time order and priority order
  always_comb begin
    res.later  = (pick_time < entry.stime);
    res.higher = (entry.pri > pick_pri);
  end

endmodule

FILE: rtl/core/oldest_priority_swap_queue_unit.sv
// ----------------------------------------------------------------------------
// oldest_priority_swap_queue_unit
// ordered entry store; insert at tail, remove oldest-first priority pick
// ----------------------------------------------------------------------------
//
//  channel   ports                                          handshake
//  --------  ---------------------------------------------  -----------------
//  command   in_op in_proc_id in_priority_req in_store_time start & !busy
//  result    out_removed_valid out_removed_id out_status    out_valid strobe
//            out_is_empty
//
//  insert and any remove on an empty queue: the result strobes in
//  the cycle after the transfer and busy stays low.
//  remove: scans from the head, up to the N entries held, one per cycle
//  through the compare unit, to find the picked slot P; then it moves the
//  later entries down one slot per cycle through the memory's single
//  write port.
//  reset (rst_n low, synchronous) empties the queue; memory is not cleared.
//  the receiver cannot stall: each result is shown for one cycle only.
// ----------------------------------------------------------------------------
module oldest_priority_swap_queue_unit
  import ospq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_op,
  input  logic [15:0] in_proc_id,
  input  logic [7:0]  in_priority_req,
  input  logic [31:0] in_store_time,
  output logic        out_valid,
  output logic        out_removed_valid,
  output logic [15:0] out_removed_id,
  output logic [1:0]  out_status,
  output logic        out_is_empty
);

  state_t         state_r, state_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [AW-1:0]  k_r, k_nxt;
  logic [AW-1:0]  w_r, w_nxt;
  logic [AW-1:0]  pick_idx_r, pick_idx_nxt;
  logic [7:0]     pick_pri_r, pick_pri_nxt;
  logic [31:0]    pick_time_r, pick_time_nxt;
  logic [15:0]    pick_id_r, pick_id_nxt;

  logic           out_valid_r, out_valid_nxt;
  logic           out_rv_r, out_rv_nxt;
  logic [15:0]    out_id_r, out_id_nxt;
  logic [1:0]     out_st_r, out_st_nxt;
  logic           out_empty_r, out_empty_nxt;

  logic           mem_wr_en;
  logic [AW-1:0]  mem_wr_addr;
  entry_t         mem_wr_data;
  logic [AW-1:0]  mem_rd_addr;
  entry_t         mem_rd_data;
  cmp_res_t       cmp_res;

  logic           accept;
  logic           is_full;
  logic           first;
  logic           stop;
  logic           take;
  logic [AW-1:0]  p_fin;
  logic [15:0]    p_fin_id;
  logic           scan_last;
  logic           no_shift;
  logic           shift_last;

  // entry memory
  ospq_store u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // compare unit, reused for every scanned entry
  ospq_cmp u_cmp (
    .pick_time (pick_time_r),
    .pick_pri  (pick_pri_r),
    .entry     (mem_rd_data),
    .res       (cmp_res)
  );

  // scan and shift decodes
  always_comb begin
    accept     = start && (state_r == S_IDLE);
    is_full    = (count_r == CW'(DEPTH));
    first      = (k_r == '0);
    stop       = !first && cmp_res.later;
    take       = first || (!stop && cmp_res.higher);
    p_fin      = take ? k_r : pick_idx_r;
    p_fin_id   = take ? mem_rd_data.id : pick_id_r;
    scan_last  = stop || ((CW'(k_r) + CW'(1)) == count_r);
    no_shift   = ((CW'(p_fin) + CW'(1)) == count_r);
    shift_last = ((CW'(w_r) + CW'(2)) == count_r);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && (in_op == OP_REMOVE) && (count_r != '0)) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_nxt = no_shift ? S_IDLE : S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (shift_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath control and results
  always_comb begin
    count_nxt     = count_r;
    k_nxt         = k_r;
    w_nxt         = w_r;
    pick_idx_nxt  = pick_idx_r;
    pick_pri_nxt  = pick_pri_r;
    pick_time_nxt = pick_time_r;
    pick_id_nxt   = pick_id_r;
    out_valid_nxt = 1'b0;
    out_rv_nxt    = out_rv_r;
    out_id_nxt    = out_id_r;
    out_st_nxt    = out_st_r;
    out_empty_nxt = out_empty_r;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = count_r[AW-1:0];
    mem_wr_data   = '{id: in_proc_id, pri: in_priority_req, stime: in_store_time};
    mem_rd_addr   = k_r + AW'(1);
    case (state_r)
      S_IDLE: begin
        mem_rd_addr = '0;
        k_nxt       = '0;
        if (accept) begin
          out_valid_nxt = 1'b1;
          out_rv_nxt    = 1'b0;
          out_id_nxt    = '0;
          if (in_op == OP_INSERT) begin
            if (is_full) begin
              out_st_nxt    = ST_FULL;
              out_empty_nxt = (count_r == '0);
            end else begin
              // tail write
              mem_wr_en     = 1'b1;
              count_nxt     = count_r + CW'(1);
              out_st_nxt    = ST_OK;
              out_empty_nxt = 1'b0;
            end
          end else if (count_r == '0) begin
            out_st_nxt    = ST_EMPTY;
            out_empty_nxt = 1'b1;
          end else begin
            // remove starts its scan; result comes later
            out_valid_nxt = 1'b0;
          end
        end
      end
      S_SCAN: begin
        // update the pick from the entry on the read port
        if (take) begin
          pick_idx_nxt  = k_r;
          pick_pri_nxt  = mem_rd_data.pri;
          pick_time_nxt = mem_rd_data.stime;
          pick_id_nxt   = mem_rd_data.id;
        end
        if (scan_last) begin
          if (no_shift) begin
            count_nxt     = count_r - CW'(1);
            out_valid_nxt = 1'b1;
            out_rv_nxt    = 1'b1;
            out_id_nxt    = p_fin_id;
            out_st_nxt    = ST_OK;
            out_empty_nxt = ((count_r - CW'(1)) == '0);
          end else begin
            // fetch the slot after the pick to begin closing the gap
            mem_rd_addr = p_fin + AW'(1);
            w_nxt       = p_fin;
          end
        end else begin
          k_nxt = k_r + AW'(1);
        end
      end
      S_SHIFT: begin
        // move one entry down per cycle
        mem_wr_en   = 1'b1;
        mem_wr_addr = w_r;
        mem_wr_data = mem_rd_data;
        mem_rd_addr = w_r + AW'(2);
        w_nxt       = w_r + AW'(1);
        if (shift_last) begin
          count_nxt     = count_r - CW'(1);
          out_valid_nxt = 1'b1;
          out_rv_nxt    = 1'b1;
          out_id_nxt    = pick_id_r;
          out_st_nxt    = ST_OK;
          out_empty_nxt = ((count_r - CW'(1)) == '0);
        end
      end
      default: begin
        mem_rd_addr = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    k_r         <= k_nxt;
    w_r         <= w_nxt;
    pick_idx_r  <= pick_idx_nxt;
    pick_pri_r  <= pick_pri_nxt;
    pick_time_r <= pick_time_nxt;
    pick_id_r   <= pick_id_nxt;
    out_rv_r    <= out_rv_nxt;
    out_id_r    <= out_id_nxt;
    out_st_r    <= out_st_nxt;
    out_empty_r <= out_empty_nxt;
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_removed_valid = out_rv_r;
  assign out_removed_id    = out_id_r;
  assign out_status        = out_st_r;
  assign out_is_empty      = out_empty_r;

endmodule

FILE: verif/ospq_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ospq_result_checker
// watches the command and result channels of the swap queue, keeps its own
// model of the stored entries, and compares every result field by field
// against the oldest outstanding prediction
// ----------------------------------------------------------------------------
module ospq_result_checker
  import ospq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_op,
  input  logic [15:0] in_proc_id,
  input  logic [7:0]  in_priority_req,
  input  logic [31:0] in_store_time,
  input  logic        out_valid,
  input  logic        out_removed_valid,
  input  logic [15:0] out_removed_id,
  input  logic [1:0]  out_status,
  input  logic        out_is_empty,
  output int          fail_count,
  output int          pending_count
);

  typedef struct packed {
    logic        removed_valid;
    logic [15:0] removed_id;
    logic [1:0]  status;
    logic        is_empty;
  } queue_result_t;

  // model of the queue contents, slot 0 oldest
  entry_t        model_slots [DEPTH];
  int            model_held;
  queue_result_t expected_results [$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
    model_held    = 0;
  end

  // apply one command to the model and return the result it should produce
  function automatic queue_result_t next_queue_result(logic op, entry_t item);
    queue_result_t res;
    int            pick;
    res = '0;
    if (op == OP_INSERT) begin
      if (model_held >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        model_slots[model_held] = item;
        model_held++;
        res.status = ST_OK;
      end
    end else if (model_held == 0) begin
      res.status = ST_EMPTY;
    end else begin
      // scan from the head; a younger stamp ends it, a strictly higher
      // priority takes over the pick
      pick = 0;
      for (int k = 1; k < model_held; k++) begin
        if (model_slots[pick].stime < model_slots[k].stime) break;
        if (model_slots[k].pri > model_slots[pick].pri) pick = k;
      end
      res.removed_valid = 1'b1;
      res.removed_id    = model_slots[pick].id;
      res.status        = ST_OK;
      // close the gap, keeping order
      for (int k = pick; k + 1 < model_held; k++) begin
        model_slots[k] = model_slots[k + 1];
      end
      model_held--;
    end
    res.is_empty = (model_held == 0);
    return res;
  endfunction

  task automatic report_field(input string label, input logic [31:0] want,
                              input logic [31:0] got, inout bit bad);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
      bad = 1'b1;
    end
  endtask

  // compare results first, then record the command transferred at this edge
  always @(posedge clk) begin : watch
    queue_result_t want;
    bit            bad;
    if (!rst_n) begin
      model_held = 0;
      expected_results.delete();
    end else begin
      if (out_valid !== 1'b0) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result strobe with nothing outstanding", $time);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          bad  = 1'b0;
          report_field("removed_valid", 32'(want.removed_valid), 32'(out_removed_valid),
                       bad);
          report_field("removed_id", 32'(want.removed_id), 32'(out_removed_id), bad);
          report_field("status", 32'(want.status), 32'(out_status), bad);
          report_field("is_empty", 32'(want.is_empty), 32'(out_is_empty), bad);
          if (bad) fail_count++;
        end
      end
      if (start && !busy) begin
        expected_results.push_back(next_queue_result(in_op,
          '{id: in_proc_id, pri: in_priority_req, stime: in_store_time}));
      end
    end
    pending_count = expected_results.size();
  end

endmodule

FILE: verif/tb_oldest_priority_swap_queue_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_oldest_priority_swap_queue_unit
// drives inserts and removes into the swap queue: a directed pass over empty
// and full queues, equal stamps and equal priorities, then random phases
// that lean toward filling or draining with stamps chosen to make long scans;
// a side checker predicts and compares, this module gives the verdict
// ----------------------------------------------------------------------------
module tb_oldest_priority_swap_queue_unit;
  import ospq_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_op;
  logic [15:0] in_proc_id;
  logic [7:0]  in_priority_req;
  logic [31:0] in_store_time;
  logic        out_valid;
  logic        out_removed_valid;
  logic [15:0] out_removed_id;
  logic [1:0]  out_status;
  logic        out_is_empty;
  int          fail_count;
  int          pending_count;

  oldest_priority_swap_queue_unit DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_op             (in_op),
    .in_proc_id        (in_proc_id),
    .in_priority_req   (in_priority_req),
    .in_store_time     (in_store_time),
    .out_valid         (out_valid),
    .out_removed_valid (out_removed_valid),
    .out_removed_id    (out_removed_id),
    .out_status        (out_status),
    .out_is_empty      (out_is_empty)
  );

  ospq_result_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_op             (in_op),
    .in_proc_id        (in_proc_id),
    .in_priority_req   (in_priority_req),
    .in_store_time     (in_store_time),
    .out_valid         (out_valid),
    .out_removed_valid (out_removed_valid),
    .out_removed_id    (out_removed_id),
    .out_status        (out_status),
    .out_is_empty      (out_is_empty),
    .fail_count        (fail_count),
    .pending_count     (pending_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // one command transfer, with an optional random gap ahead of it
  task automatic send_command(input logic op, input logic [15:0] pid,
                              input logic [7:0] pri, input logic [31:0] stamp,
                              input bit may_idle);
    int gap;
    gap = 0;
    while (may_idle && ($urandom_range(0, 99) < 23)) gap++;
    if (gap > 0) begin
      // junk on the fields while start is low
      start           <= 1'b0;
      in_op           <= 1'($urandom_range(0, 1));
      in_proc_id      <= 16'($urandom_range(0, 65535));
      in_priority_req <= 8'($urandom_range(0, 255));
      in_store_time   <= $urandom();
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    in_op           <= op;
    in_proc_id      <= pid;
    in_priority_req <= pri;
    in_store_time   <= stamp;
    do @(posedge clk); while (busy);
  endtask

  task automatic send_remove(input bit may_idle);
    send_command(OP_REMOVE, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                 $urandom(), may_idle);
  endtask

  // stimulus and verdict
  initial begin
    int          insert_pct;
    int          stamp_mode;
    int          drain;
    logic [31:0] stamp_base;
    logic [31:0] stamp;
    logic [7:0]  pri;
    logic        op;

    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_op           <= OP_INSERT;
    in_proc_id      <= '0;
    in_priority_req <= '0;
    in_store_time   <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: remove from empty, lowest values, then fill past full
    send_remove(1'b1);
    send_command(OP_INSERT, 16'h0000, 8'h00, 32'h0000_0000, 1'b1);
    send_remove(1'b1);
    // pairs of equal stamps descending, one youngest stamp mid-queue,
    // priorities with ties at both extremes; the last transfer hits a full queue
    for (int i = 0; i <= DEPTH; i++) begin
      send_command(OP_INSERT, (i == DEPTH - 1) ? 16'hFFFF : 16'(i),
                   (i % 5 == 0) ? 8'h00 : (i % 5 == 3) ? 8'hFF : 8'(i * 16),
                   (i == 9) ? 32'hFFFF_FFFF : 32'hFFFF_FFF0 - 32'(i / 2), 1'b1);
    end
    for (int i = 0; i < 5; i++) send_remove(1'b1);

    // random phases of 50 transfers; quiet stretch with no gaps in the middle
    insert_pct = 55;
    stamp_mode = 0;
    stamp_base = 32'hFFFF_FF00;
    for (int n = 0; n < 625; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(0, 2))
          0:       insert_pct = 80;
          1:       insert_pct = 25;
          default: insert_pct = 55;
        endcase
        stamp_mode = $urandom_range(0, 2);
      end
      op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
      case (stamp_mode)
        0: begin
          // few distinct stamps, so ties are common
          if ($urandom_range(0, 9) == 0) stamp = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
          else stamp = $urandom_range(0, 7);
        end
        1: begin
          // mostly non-increasing stamps give long scans
          if ($urandom_range(0, 9) == 0) stamp_base = stamp_base + $urandom_range(1, 64);
          else stamp_base = stamp_base - $urandom_range(0, 2);
          stamp = stamp_base;
        end
        default: stamp = $urandom();
      endcase
      pri = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
      send_command(op, 16'($urandom_range(0, 65535)), pri, stamp,
                   !(n >= 200 && n < 360));
    end
    start <= 1'b0;

    // drain outstanding results, then let any stray strobe show up
    drain = 0;
    while (pending_count != 0 && drain < 2000) begin
      @(posedge clk);
      drain++;
    end
    repeat (2 * DEPTH + 4) @(posedge clk);
    if (pending_count != 0) $display("%0t: %0d results never arrived", $time, pending_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
